// ----- rtl/icp_pkg.sv -----
// Shared constants and types of the IRC format code parser.
package icp_pkg;

    // Palette size and derived address width
    localparam int PALETTE_ENTRIES = 16;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int HEX_DIGITS      = 6;
    localparam int PEND_W          = $clog2(HEX_DIGITS + 1);
    localparam int COLOR_W         = 24;
    localparam int CODE_DEFAULT    = 99;

    // Control bytes
    localparam logic [7:0] CH_BOLD   = 8'h02;
    localparam logic [7:0] CH_PAL    = 8'h03;
    localparam logic [7:0] CH_HEX    = 8'h04;
    localparam logic [7:0] CH_DROP_A = 8'h06;
    localparam logic [7:0] CH_HILITE = 8'h07;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_RESET  = 8'h0F;
    localparam logic [7:0] CH_DROP_B = 8'h12;
    localparam logic [7:0] CH_DROP_C = 8'h13;
    localparam logic [7:0] CH_SWAP   = 8'h16;
    localparam logic [7:0] CH_ITALIC = 8'h1D;
    localparam logic [7:0] CH_UNDER  = 8'h1F;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Control modes
    localparam logic [1:0] MODE_RAW    = 2'd0;
    localparam logic [1:0] MODE_STRIP  = 2'd1;
    localparam logic [1:0] MODE_INTERP = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_CONTROL_MODE = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_FG   = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_BG   = 2'd2;

    typedef enum logic [3:0] {
        PH_START, PH_IDLE, PH_FG1, PH_FG2, PH_COMMA,
        PH_BG1, PH_BG2, PH_HFG, PH_HCOMMA, PH_HBG
    } phase_t;

    // Parser state
    typedef struct packed {
        phase_t                     phase;
        logic [HEX_DIGITS-1:0][7:0] pend;
        logic [PEND_W-1:0]          pend_cnt;
        logic [COLOR_W-1:0]         fg_val;
        logic [COLOR_W-1:0]         bg_val;
        logic [2:0]                 fg_cnt;
        logic                       hl;
        logic [2:0]                 eff;
        logic [COLOR_W-1:0]         cur_fg;
        logic [COLOR_W-1:0]         cur_bg;
        logic [COLOR_W-1:0]         sav_fg;
        logic [COLOR_W-1:0]         sav_bg;
    } pst_t;

    // Outcome of one byte
    typedef struct packed {
        pst_t               st;
        logic               consumed;
        logic               emit_c;
        logic [PEND_W-1:0]  flush_n;
        logic [2:0]         a_eff;
        logic [COLOR_W-1:0] a_fg;
        logic [COLOR_W-1:0] a_bg;
        logic [PAL_AW-1:0]  fidx;
        logic [PAL_AW-1:0]  bidx;
    } step_t;

endpackage

// ----- rtl/icp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module icp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/irc_format_code_parser_unit.sv -----
// IRC format code parser: message bytes in, attributed characters out.
//
// Input channel (s_*): one request is either a message byte (s_func 0) or a
// palette write (s_func 1). Result channel (m_*): characters tagged with
// bold, underline, italic and 24-bit RGB colors; the last result of a final
// byte carries m_end_of_message, and a final byte that shows nothing gives
// one empty marker (m_is_text 0, m_end_of_message 1, all other fields 0).
// Configuration (cfg_*): control mode, default fg and bg colors; cfg_ready
// is always high, writes are meant for idle periods only.
// Timing: a request is resolved in the cycle after it is taken, when the
// palette memories return the color for the code being closed. The first
// result of a message byte enters the output register at the end of the
// resolving cycle if that register is free, else it waits in a small result
// buffer; further results (pushed-back hex digits, up to five more per byte)
// drain one per cycle while taken, and s_ready stays low until it is empty.
// Receiver stall: the output register holds its result; the next request is
// still accepted while it waits, its results are buffered.
// Reset: the parser returns to message start, the palette reads as zero
// (per-entry valid bits), the registers take their reset values.
module irc_format_code_parser_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [7:0]                   s_byte_value,
    input  logic                         s_last_of_message,
    input  logic [3:0]                   s_palette_index,
    input  logic [icp_pkg::COLOR_W-1:0]  s_palette_color,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_text,
    output logic [7:0]                   m_char_out,
    output logic                         m_bold,
    output logic                         m_underline,
    output logic                         m_italic,
    output logic [icp_pkg::COLOR_W-1:0]  m_fg_color,
    output logic [icp_pkg::COLOR_W-1:0]  m_bg_color,
    output logic                         m_end_of_message,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [icp_pkg::COLOR_W-1:0]  cfg_data
);
    import icp_pkg::*;

    // ---------------- parser functions ----------------
    function automatic logic [4:0] hexv(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic two_ok(input logic [6:0] n);
        return (32'(n) < PALETTE_ENTRIES) || (n == 7'(CODE_DEFAULT));
    endfunction

    function automatic logic pal_hit(input logic [COLOR_W-1:0] n);
        return (n != COLOR_W'(CODE_DEFAULT)) && (32'(n) < PALETTE_ENTRIES);
    endfunction

    function automatic step_t snap(input step_t r);
        step_t o;
        o = r;
        o.a_eff = r.st.eff;
        o.a_fg  = r.st.cur_fg;
        o.a_bg  = r.st.cur_bg;
        return o;
    endfunction

    function automatic step_t fin_pal(input step_t r, input logic hf, input logic hb,
                                      input logic [1:0] mode,
                                      input logic [COLOR_W-1:0] dfg, dbg, rdf, rdb);
        step_t o;
        o = r;
        if (hf) o.fidx = r.st.fg_val[PAL_AW-1:0];
        if (hb) o.bidx = r.st.bg_val[PAL_AW-1:0];
        if (mode == MODE_INTERP) begin
            if (hf) o.st.cur_fg = pal_hit(r.st.fg_val) ? rdf : dfg;
            if (hb) o.st.cur_bg = pal_hit(r.st.bg_val) ? rdb : dbg;
            if (!hf && !hb) begin
                o.st.cur_fg = dfg;
                o.st.cur_bg = dbg;
            end
        end
        o.st.phase = PH_IDLE;
        return o;
    endfunction

    function automatic step_t fin_hex(input step_t r, input logic fok, input logic bok,
                                      input logic [1:0] mode,
                                      input logic [COLOR_W-1:0] dfg, dbg);
        step_t o;
        o = r;
        if (mode == MODE_INTERP || r.st.hl) begin
            if (fok || bok) begin
                if (r.st.hl) begin
                    o.st.sav_fg = r.st.cur_fg;
                    o.st.sav_bg = r.st.cur_bg;
                end
                if (fok) o.st.cur_fg = r.st.fg_val;
                if (bok) o.st.cur_bg = r.st.bg_val;
            end else begin
                o.st.eff = '0;
                o.st.cur_fg = r.st.hl ? r.st.sav_fg : dfg;
                o.st.cur_bg = r.st.hl ? r.st.sav_bg : dbg;
            end
        end
        o.st.phase = PH_IDLE;
        return o;
    endfunction

    function automatic step_t flush(input step_t r);
        step_t o;
        o = r;
        o.flush_n = r.st.pend_cnt;
        if (r.st.pend_cnt != '0) o = snap(o);
        o.st.pend_cnt = '0;
        return o;
    endfunction

    // Feed a byte (isb 1) or the end of message (isb 0) to an open code
    function automatic step_t adv(input step_t r, input logic [7:0] c, input logic isb,
                                  input logic [1:0] mode,
                                  input logic [COLOR_W-1:0] dfg, dbg, rdf, rdb);
        step_t      o;
        logic       dig;
        logic       com;
        logic       hok;
        logic [4:0] hv;
        logic [3:0] d;
        logic [6:0] n;
        logic       done;
        o = r;
        o.consumed = 1'b0;
        dig  = isb && c >= 8'h30 && c <= 8'h39;
        com  = isb && c == CH_COMMA;
        hv   = hexv(c);
        hok  = isb && hv[4];
        d    = 4'(c - 8'h30);
        done = 1'b0;
        n    = '0;
        // leading digits
        case (o.st.phase)
            PH_FG1: begin
                if (dig) begin
                    o.st.fg_val = COLOR_W'(d);
                    o.st.fg_cnt = 3'd1;
                    o.st.phase  = PH_FG2;
                    o.consumed  = 1'b1;
                    done = 1'b1;
                end else begin
                    o.st.fg_cnt = '0;
                    o.st.phase  = PH_COMMA;
                end
            end
            PH_FG2: begin
                n = 7'(o.st.fg_val[3:0]) * 7'd10 + 7'(d);
                if (dig && two_ok(n)) begin
                    o.st.fg_val = COLOR_W'(n);
                    o.st.fg_cnt = 3'd2;
                    o.consumed  = 1'b1;
                    done = 1'b1;
                end
                o.st.phase = PH_COMMA;
            end
            PH_HFG: begin
                if (hok && 32'(o.st.pend_cnt) < HEX_DIGITS) begin
                    o.st.pend[o.st.pend_cnt] = c;
                    o.st.pend_cnt = o.st.pend_cnt + 1'b1;
                    o.st.fg_val = {o.st.fg_val[COLOR_W-5:0], hv[3:0]};
                    if (32'(o.st.pend_cnt) >= HEX_DIGITS) begin
                        o.st.fg_cnt   = 3'(HEX_DIGITS);
                        o.st.pend_cnt = '0;
                        o.st.phase    = PH_HCOMMA;
                    end
                    o.consumed = 1'b1;
                    done = 1'b1;
                end else begin
                    o.st.fg_cnt = '0;
                    if (o.st.pend_cnt != '0) begin
                        o = fin_hex(o, 1'b0, 1'b0, mode, dfg, dbg);
                        o = flush(o);
                        done = 1'b1;
                    end else begin
                        o.st.phase = PH_HCOMMA;
                    end
                end
            end
            default: ;
        endcase
        // separator and background
        if (!done) begin
            case (o.st.phase)
                PH_COMMA: begin
                    if (com) begin
                        o.st.bg_val = '0;
                        o.st.phase  = PH_BG1;
                        o.consumed  = 1'b1;
                    end else begin
                        o = fin_pal(o, o.st.fg_cnt != '0, 1'b0, mode, dfg, dbg, rdf, rdb);
                    end
                end
                PH_BG1: begin
                    if (dig) begin
                        o.st.bg_val = COLOR_W'(d);
                        o.st.phase  = PH_BG2;
                        o.consumed  = 1'b1;
                    end else begin
                        o = fin_pal(o, o.st.fg_cnt != '0, 1'b0, mode, dfg, dbg, rdf, rdb);
                    end
                end
                PH_BG2: begin
                    n = 7'(o.st.bg_val[3:0]) * 7'd10 + 7'(d);
                    if (dig && two_ok(n)) begin
                        o.st.bg_val = COLOR_W'(n);
                        o.consumed  = 1'b1;
                    end
                    o = fin_pal(o, o.st.fg_cnt != '0, 1'b1, mode, dfg, dbg, rdf, rdb);
                end
                PH_HCOMMA: begin
                    if (com) begin
                        o.st.bg_val   = '0;
                        o.st.pend_cnt = '0;
                        o.st.phase    = PH_HBG;
                        o.consumed    = 1'b1;
                    end else begin
                        o = fin_hex(o, o.st.fg_cnt == 3'(HEX_DIGITS), 1'b0, mode, dfg, dbg);
                    end
                end
                PH_HBG: begin
                    if (hok && 32'(o.st.pend_cnt) < HEX_DIGITS) begin
                        o.st.pend[o.st.pend_cnt] = c;
                        o.st.pend_cnt = o.st.pend_cnt + 1'b1;
                        o.st.bg_val = {o.st.bg_val[COLOR_W-5:0], hv[3:0]};
                        if (32'(o.st.pend_cnt) >= HEX_DIGITS) begin
                            o.st.pend_cnt = '0;
                            o = fin_hex(o, o.st.fg_cnt == 3'(HEX_DIGITS), 1'b1, mode,
                                        dfg, dbg);
                        end
                        o.consumed = 1'b1;
                    end else begin
                        o = fin_hex(o, o.st.fg_cnt == 3'(HEX_DIGITS), 1'b0, mode, dfg, dbg);
                        o = flush(o);
                    end
                end
                default: ;
            endcase
        end
        return o;
    endfunction

    // Byte outside any code
    function automatic step_t proc_idle(input step_t r, input logic [7:0] c,
                                        input logic [1:0] mode,
                                        input logic [COLOR_W-1:0] dfg, dbg);
        step_t o;
        logic  strip;
        o = r;
        strip = (mode == MODE_STRIP);
        if (mode == MODE_RAW) begin
            if (c != CH_CR) begin
                o.emit_c = 1'b1;
                o = snap(o);
            end
        end else begin
            case (c)
                CH_BOLD:   if (!strip) o.st.eff[0] = !o.st.eff[0];
                CH_UNDER:  if (!strip) o.st.eff[1] = !o.st.eff[1];
                CH_ITALIC: if (!strip) o.st.eff[2] = !o.st.eff[2];
                CH_SWAP: begin
                    if (!strip) begin
                        o.st.cur_fg = r.st.cur_bg;
                        o.st.cur_bg = r.st.cur_fg;
                    end
                end
                CH_RESET: begin
                    if (!strip) begin
                        o.st.eff    = '0;
                        o.st.cur_fg = dfg;
                        o.st.cur_bg = dbg;
                    end
                end
                CH_PAL: begin
                    o.st.fg_val = '0;
                    o.st.bg_val = '0;
                    o.st.fg_cnt = '0;
                    o.st.phase  = PH_FG1;
                end
                CH_HEX, CH_HILITE: begin
                    o.st.hl       = (c == CH_HILITE);
                    o.st.fg_val   = '0;
                    o.st.bg_val   = '0;
                    o.st.fg_cnt   = '0;
                    o.st.pend_cnt = '0;
                    o.st.phase    = PH_HFG;
                end
                CH_DROP_A, CH_DROP_B, CH_DROP_C: ;
                default: begin
                    o.emit_c = 1'b1;
                    o = snap(o);
                end
            endcase
        end
        return o;
    endfunction

    function automatic step_t do_step(input pst_t s, input logic [7:0] c, input logic last,
                                      input logic [1:0] mode,
                                      input logic [COLOR_W-1:0] dfg, dbg, rdf, rdb);
        step_t r;
        r = '0;
        r.st = s;
        if (s.phase == PH_START) begin
            r.st.cur_fg   = dfg;
            r.st.cur_bg   = dbg;
            r.st.sav_fg   = dfg;
            r.st.sav_bg   = dbg;
            r.st.eff      = '0;
            r.st.pend_cnt = '0;
            r.st.phase    = PH_IDLE;
        end
        r = adv(r, c, 1'b1, mode, dfg, dbg, rdf, rdb);
        if (!r.consumed) r = proc_idle(r, c, mode, dfg, dbg);
        if (last) begin
            if (r.st.phase != PH_IDLE) r = adv(r, 8'h00, 1'b0, mode, dfg, dbg, rdf, rdb);
            r.st.phase = PH_START;
        end
        return r;
    endfunction

    // ---------------- registers ----------------
    pst_t                       st_reg;
    logic                       busy_reg;
    logic [7:0]                 it_c_reg;
    logic                       it_last_reg;
    logic                       it_func_reg;
    logic [1:0]                 mode_reg;
    logic [COLOR_W-1:0]         dfg_reg;
    logic [COLOR_W-1:0]         dbg_reg;
    logic [PALETTE_ENTRIES-1:0] pal_vld_reg;
    logic                       rdf_vld_reg;
    logic                       rdb_vld_reg;

    // result buffer
    logic [HEX_DIGITS-1:0][7:0] jb_reg;
    logic [PEND_W-1:0]          job_len_reg;
    logic [PEND_W-1:0]          job_rd_reg;
    logic                       job_mark_reg;
    logic                       job_end_reg;
    logic [2:0]                 job_eff_reg;
    logic [COLOR_W-1:0]         job_fg_reg;
    logic [COLOR_W-1:0]         job_bg_reg;

    // output register
    logic                       m_valid_reg;
    logic                       m_is_text_reg;
    logic [7:0]                 m_char_reg;
    logic [2:0]                 m_eff_reg;
    logic [COLOR_W-1:0]         m_fg_reg;
    logic [COLOR_W-1:0]         m_bg_reg;
    logic                       m_end_reg;

    // ---------------- palette memories ----------------
    logic                       s_acc;
    logic                       pal_we;
    logic [PAL_AW-1:0]          pal_waddr;
    logic [COLOR_W-1:0]         rdf_ram;
    logic [COLOR_W-1:0]         rdb_ram;
    logic [COLOR_W-1:0]         rdf;
    logic [COLOR_W-1:0]         rdb;
    step_t                      step0;
    step_t                      step1;

    assign s_acc     = s_valid && s_ready;
    assign pal_we    = s_acc && s_func && (32'(s_palette_index) < PALETTE_ENTRIES);
    assign pal_waddr = PAL_AW'(s_palette_index);

    // first pass only finds the palette entries the byte will close on
    assign step0 = do_step(st_reg, s_byte_value, s_last_of_message, mode_reg,
                           dfg_reg, dbg_reg, '0, '0);

    icp_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_pal_fg (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (s_palette_color),
        .raddr (step0.fidx),
        .rdata (rdf_ram)
    );

    icp_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_pal_bg (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (s_palette_color),
        .raddr (step0.bidx),
        .rdata (rdb_ram)
    );

    assign rdf = rdf_vld_reg ? rdf_ram : '0;
    assign rdb = rdb_vld_reg ? rdb_ram : '0;

    // second pass resolves the byte with the palette data
    assign step1 = do_step(st_reg, it_c_reg, it_last_reg, mode_reg,
                           dfg_reg, dbg_reg, rdf, rdb);

    // ---------------- result assembly ----------------
    logic [HEX_DIGITS-1:0][7:0] lst;
    logic [PEND_W-1:0]          n_txt;
    logic                       mark;
    logic [PEND_W-1:0]          n_res;
    logic                       out_free;
    logic                       direct;
    logic                       drain;
    logic                       job_busy;
    logic                       load;
    logic                       o_text;
    logic [7:0]                 o_char;
    logic [2:0]                 o_eff;
    logic [COLOR_W-1:0]         o_fg;
    logic [COLOR_W-1:0]         o_bg;
    logic                       o_end;

    always_comb begin
        for (int i = 0; i < HEX_DIGITS; i++) begin
            lst[i] = (PEND_W'(i) < step1.flush_n) ? step1.st.pend[i] : it_c_reg;
        end
        n_txt    = step1.flush_n + PEND_W'(step1.emit_c);
        mark     = it_last_reg && (n_txt == '0);
        n_res    = mark ? PEND_W'(1) : n_txt;
        out_free = !m_valid_reg || m_ready;
        job_busy = (job_rd_reg != job_len_reg);
        direct   = busy_reg && !it_func_reg && (n_res != '0) && out_free;
        drain    = !busy_reg && job_busy && out_free;
        load     = direct || drain;
        if (direct) begin
            o_text = !mark;
            o_char = mark ? 8'h00 : lst[0];
            o_eff  = mark ? 3'b000 : step1.a_eff;
            o_fg   = mark ? '0 : step1.a_fg;
            o_bg   = mark ? '0 : step1.a_bg;
            o_end  = it_last_reg && (n_res == PEND_W'(1));
        end else begin
            o_text = !job_mark_reg;
            o_char = job_mark_reg ? 8'h00 : jb_reg[job_rd_reg];
            o_eff  = job_mark_reg ? 3'b000 : job_eff_reg;
            o_fg   = job_mark_reg ? '0 : job_fg_reg;
            o_bg   = job_mark_reg ? '0 : job_bg_reg;
            o_end  = job_end_reg && (job_rd_reg == job_len_reg - 1'b1);
        end
    end

    assign s_ready   = !busy_reg && !job_busy;
    assign cfg_ready = 1'b1;

    // ---------------- sequential ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '{phase: PH_START, cur_bg: '1, sav_bg: '1, default: '0};
            busy_reg      <= 1'b0;
            mode_reg      <= MODE_INTERP;
            dfg_reg       <= '0;
            dbg_reg       <= '1;
            pal_vld_reg   <= '0;
            rdf_vld_reg   <= 1'b0;
            rdb_vld_reg   <= 1'b0;
            job_len_reg   <= '0;
            job_rd_reg    <= '0;
            job_mark_reg  <= 1'b0;
            job_end_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CONTROL_MODE: mode_reg <= cfg_data[1:0];
                    CFG_DEFAULT_FG:   dfg_reg  <= cfg_data;
                    CFG_DEFAULT_BG:   dbg_reg  <= cfg_data;
                    default: ;
                endcase
            end
            // take a request
            if (s_acc) begin
                busy_reg    <= 1'b1;
                it_c_reg    <= s_byte_value;
                it_last_reg <= s_last_of_message;
                it_func_reg <= s_func;
                if (pal_we) pal_vld_reg[pal_waddr] <= 1'b1;
            end else begin
                busy_reg <= 1'b0;
            end
            rdf_vld_reg <= pal_vld_reg[step0.fidx];
            rdb_vld_reg <= pal_vld_reg[step0.bidx];
            // resolve a message byte
            if (busy_reg && !it_func_reg) begin
                st_reg       <= step1.st;
                jb_reg       <= lst;
                job_len_reg  <= n_res;
                job_rd_reg   <= direct ? PEND_W'(1) : '0;
                job_mark_reg <= mark;
                job_end_reg  <= it_last_reg;
                job_eff_reg  <= step1.a_eff;
                job_fg_reg   <= step1.a_fg;
                job_bg_reg   <= step1.a_bg;
            end else if (drain) begin
                job_rd_reg <= job_rd_reg + 1'b1;
            end
            // output register
            if (load) begin
                m_valid_reg   <= 1'b1;
                m_is_text_reg <= o_text;
                m_char_reg    <= o_char;
                m_eff_reg     <= o_eff;
                m_fg_reg      <= o_fg;
                m_bg_reg      <= o_bg;
                m_end_reg     <= o_end;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_is_text        = m_is_text_reg;
    assign m_char_out       = m_char_reg;
    assign m_bold           = m_eff_reg[0];
    assign m_underline      = m_eff_reg[1];
    assign m_italic         = m_eff_reg[2];
    assign m_fg_color       = m_fg_reg;
    assign m_bg_color       = m_bg_reg;
    assign m_end_of_message = m_end_reg;

endmodule

// ----- rtl/icp_checker.sv -----
// Port-level checks of the IRC format code parser, bound to the top level.
module icp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_is_text,
    input logic [7:0]  m_char_out,
    input logic [23:0] m_fg_color,
    input logic [23:0] m_bg_color,
    input logic        m_end_of_message
);
    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_char_out) && $stable(m_fg_color))
        else $error("stalled result changed");

    // no request is taken in the cycle after one is taken, while it resolves
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one resolves");

    // an end marker is empty and closes the message
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_text |-> m_end_of_message && m_char_out == 8'h00
            && m_fg_color == 24'h0 && m_bg_color == 24'h0)
        else $error("malformed end marker");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind irc_format_code_parser_unit icp_checker u_icp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_is_text        (m_is_text),
    .m_char_out       (m_char_out),
    .m_fg_color       (m_fg_color),
    .m_bg_color       (m_bg_color),
    .m_end_of_message (m_end_of_message)
);
